// ----- sv/x86_multiply_divide_unit_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multiply/divide unit
// Shared property shorthands used by the top level checks
// ----------------------------------------------------------------------------
`ifndef X86_MULTIPLY_DIVIDE_UNIT_TOP_DEFINES_SVH
`define X86_MULTIPLY_DIVIDE_UNIT_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MDU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mdu_pkg.sv -----
// ----------------------------------------------------------------------------
// mdu_pkg
// Types and codes shared by the multiply/divide unit
// ----------------------------------------------------------------------------
package mdu_pkg;

    localparam int XLEN = 32;
    localparam int DLEN = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] OP_MUL8   = 3'd0;
    localparam logic [2:0] OP_MUL32  = 3'd1;
    localparam logic [2:0] OP_IMUL3  = 3'd2;
    localparam logic [2:0] OP_IMUL2  = 3'd3;
    localparam logic [2:0] OP_IMUL1  = 3'd4;
    localparam logic [2:0] OP_DIV    = 3'd5;
    localparam logic [2:0] OP_IDIV   = 3'd6;
    localparam logic [2:0] OP_INVAL  = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVERR  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_LO16 = 2'd1;
    localparam logic [1:0] WR_FULL = 2'd2;

    // operation class decided in the front end
    localparam logic [1:0] CL_MUL  = 2'd0;
    localparam logic [1:0] CL_DIV  = 2'd1;
    localparam logic [1:0] CL_INV  = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] high_in;
        logic [31:0] instr_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic [1:0]  write_low;
        logic        write_high;
        logic        flags_valid;
        logic        overflow;
        logic [31:0] fault_addr;
    } rsp_t;

    // classified, operand-conditioned work item
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  cls;
        logic        neg_q;     // signed divide: quotient negative
        logic        neg_r;     // signed divide: dividend negative
        logic        div_err;   // error known up front (zero divisor; unsigned divide also high >= divisor)
        logic [63:0] dvd;       // magnitude of dividend
        logic [31:0] dvs;       // magnitude of divisor
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] instr_addr;
    } work_t;

endpackage

// ----- sv/mdu_if.sv -----
// ----------------------------------------------------------------------------
// mdu_if
// Valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface mdu_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/x86_multiply_divide_unit_top.sv -----
// ----------------------------------------------------------------------------
// x86_multiply_divide_unit_top
// MUL/IMUL/DIV/IDIV execute unit, 32-bit operand size
// ----------------------------------------------------------------------------
// Takes one request per cycle while the front-end queue has room and returns
// one result per request, in order. The pipeline is one entry stage holding
// the 32x32 multiplier, 32 restoring divide stages (one quotient bit
// each, used only by divides), one result-forming stage and the output
// register. A queue of QUEUE_DEPTH entries (four by default) in the front end
// absorbs input bursts while the pipeline is stalled by the output side.
module x86_multiply_divide_unit_top #(
    parameter int QUEUE_DEPTH = mdu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mdu_if.sink   req,
    mdu_if.source rsp
);
    import mdu_pkg::*;
`include "x86_multiply_divide_unit_top_defines.svh"

    logic  q_valid, q_ready;
    work_t q_data;

    // front end: classify and queue
    mdu_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_data  (req.data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    // back end: execute pipeline
    mdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );

    // checks
    `MDU_ASSERT_IMPL(a_err_nowrite, clk, rst_n, rsp.valid && rsp.data.status != ST_OK,
        rsp.data.write_low == WR_NONE && !rsp.data.write_high, "write on error")
    `MDU_ASSERT_IMPL(a_flags_mul, clk, rst_n, rsp.valid && rsp.data.flags_valid,
        rsp.data.status == ST_OK, "flags on non-multiply")
    `MDU_ASSERT_NEXT(a_hold, clk, rst_n, rsp.valid && !rsp.ready,
        rsp.valid && $stable(rsp.data), "stalled result changed")
endmodule

// ----- sv/mdu_front.sv -----
// ----------------------------------------------------------------------------
// mdu_front
// Classifies requests and conditions divide operands into a small queue
// ----------------------------------------------------------------------------
module mdu_front #(
    parameter int QUEUE_DEPTH = mdu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mdu_pkg::req_t       in_data,
    output logic                q_valid,
    input  logic                q_ready,
    output mdu_pkg::work_t      q_data
);
    import mdu_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    work_t             mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       cnt_reg, cnt_next;
    work_t             cls_w;
    logic              push, pop;
    logic              nd, nv;
    logic [63:0]       dvd_raw;

    // classification and sign handling
    always_comb
    begin
        dvd_raw = {in_data.high_in, in_data.op_a};
        nd = dvd_raw[63];
        nv = in_data.op_b[31];
        cls_w = '0;
        cls_w.op = in_data.req_type;
        cls_w.op_a = in_data.op_a;
        cls_w.op_b = in_data.op_b;
        cls_w.instr_addr = in_data.instr_addr;
        unique case (in_data.req_type)
            OP_DIV:
            begin
                cls_w.cls = CL_DIV;
                cls_w.dvd = dvd_raw;
                cls_w.dvs = in_data.op_b;
                cls_w.div_err = (in_data.op_b == '0) || (in_data.high_in >= in_data.op_b);
            end
            OP_IDIV:
            begin
                cls_w.cls = CL_DIV;
                cls_w.dvd = nd ? (64'd0 - dvd_raw) : dvd_raw;
                cls_w.dvs = nv ? (32'd0 - in_data.op_b) : in_data.op_b;
                cls_w.neg_q = nd ^ nv;
                cls_w.neg_r = nd;
                cls_w.div_err = (in_data.op_b == '0);
            end
            OP_INVAL:
                cls_w.cls = CL_INV;
            default:
                cls_w.cls = CL_MUL;
        endcase
    end

    assign in_ready = (cnt_reg != QUEUE_DEPTH[PW:0]);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_data = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= cls_w;
    end
endmodule

// ----- sv/mdu_back.sv -----
// ----------------------------------------------------------------------------
// mdu_back
// Pipelined execute: multiply in the entry stage, divide as a restoring array
// ----------------------------------------------------------------------------
module mdu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  mdu_pkg::work_t    q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mdu_pkg::rsp_t     out_data
);
    import mdu_pkg::*;

    // 32 divide steps, one per stage, plus an entry and an exit stage
    localparam int NSTG = XLEN + 2;

    typedef struct packed {
        work_t       w;
        logic [63:0] prod;
        logic [31:0] rem;
        logic [31:0] quo;
    } stage_t;

    stage_t         stg_reg [NSTG];
    logic [NSTG-1:0] vld_reg;
    stage_t         stg_next [NSTG];
    logic [NSTG-1:0] adv;
    logic            skid_full_reg;
    rsp_t            skid_reg;
    rsp_t            fin;
    logic            last_ok;

    // the pipeline advances when its tail is free
    assign last_ok = !skid_full_reg || out_ready;
    always_comb
    begin
        adv[NSTG-1] = last_ok || !vld_reg[NSTG-1];
        for (int i = NSTG - 2; i >= 0; i--)
            adv[i] = adv[i+1] || !vld_reg[i];
    end
    assign q_ready = adv[0];

    // entry stage: signed/unsigned 32x32 product
    logic signed [32:0] ma, mb;
    logic signed [63:0] mprod;
    stage_t             stg0_next;
    always_comb
    begin
        stg0_next.w = q_data;
        stg0_next.rem = '0;
        stg0_next.quo = q_data.dvd[31:0];
        ma = (q_data.op == OP_MUL32 || q_data.op == OP_MUL8) ? {1'b0, q_data.op_a}
                                                              : {q_data.op_a[31], q_data.op_a};
        mb = (q_data.op == OP_MUL32 || q_data.op == OP_MUL8) ? {1'b0, q_data.op_b}
                                                              : {q_data.op_b[31], q_data.op_b};
        if (q_data.op == OP_MUL8)
        begin
            ma = {25'd0, q_data.op_a[7:0]};
            mb = {25'd0, q_data.op_b[7:0]};
        end
        mprod = ma * mb;
        stg0_next.prod = mprod;
        if (q_data.cls == CL_DIV)
        begin
            stg0_next.rem = q_data.dvd[63:32];
            stg0_next.prod = '0;
        end
    end

    // divide step stages: one quotient bit each
    logic [32:0] trial [XLEN];
    always_comb
    begin
        stg_next[0] = stg0_next;
        for (int i = 1; i <= XLEN; i++)
        begin
            stg_next[i] = stg_reg[i-1];
            trial[i-1] = {stg_reg[i-1].rem, stg_reg[i-1].quo[31]} - {1'b0, stg_reg[i-1].w.dvs};
            if (stg_reg[i-1].w.cls == CL_DIV)
            begin
                // dividend high part can exceed divisor (signed): keep 33-bit remainder
                if (!trial[i-1][32] || stg_reg[i-1].rem[31])
                begin
                    stg_next[i].rem = trial[i-1][31:0];
                    stg_next[i].quo = {stg_reg[i-1].quo[30:0], 1'b1};
                end
                else
                begin
                    stg_next[i].rem = {stg_reg[i-1].rem[30:0], stg_reg[i-1].quo[31]};
                    stg_next[i].quo = {stg_reg[i-1].quo[30:0], 1'b0};
                end
            end
        end
        stg_next[NSTG-1] = stg_reg[NSTG-2];
    end

    // signed divide quotient range check needs the high quotient: in idiv the
    // high half of |dividend| is below 2^31 unless overflow, detected below
    logic [31:0] qn, rn;
    logic        q_big, hi_over;
    always_comb
    begin
        fin = '0;
        qn = stg_reg[NSTG-1].w.neg_q ? (32'd0 - stg_reg[NSTG-1].quo) : stg_reg[NSTG-1].quo;
        rn = stg_reg[NSTG-1].w.neg_r ? (32'd0 - stg_reg[NSTG-1].rem) : stg_reg[NSTG-1].rem;
        hi_over = (stg_reg[NSTG-1].w.dvd[63:32] >= stg_reg[NSTG-1].w.dvs);
        q_big = stg_reg[NSTG-1].w.neg_q ? (stg_reg[NSTG-1].quo > 32'h8000_0000)
                                        : stg_reg[NSTG-1].quo[31];
        unique case (stg_reg[NSTG-1].w.cls)
            CL_INV:
                fin.status = ST_INVALID;
            CL_DIV:
            begin
                if (stg_reg[NSTG-1].w.div_err
                    || (stg_reg[NSTG-1].w.op == OP_IDIV && (hi_over || q_big)))
                begin
                    fin.status = ST_DIVERR;
                    fin.fault_addr = stg_reg[NSTG-1].w.instr_addr;
                end
                else
                begin
                    fin.result_low = (stg_reg[NSTG-1].w.op == OP_IDIV) ? qn
                                                                        : stg_reg[NSTG-1].quo;
                    fin.result_high = (stg_reg[NSTG-1].w.op == OP_IDIV) ? rn
                                                                         : stg_reg[NSTG-1].rem;
                    fin.write_low = WR_FULL;
                    fin.write_high = 1'b1;
                end
            end
            default:
            begin
                fin.flags_valid = 1'b1;
                unique case (stg_reg[NSTG-1].w.op)
                    OP_MUL8:
                    begin
                        fin.result_low = {16'd0, stg_reg[NSTG-1].prod[15:0]};
                        fin.write_low = WR_LO16;
                        fin.overflow = |stg_reg[NSTG-1].prod[15:8];
                    end
                    OP_MUL32:
                    begin
                        fin.result_low = stg_reg[NSTG-1].prod[31:0];
                        fin.result_high = stg_reg[NSTG-1].prod[63:32];
                        fin.write_low = WR_FULL;
                        fin.write_high = 1'b1;
                        fin.overflow = |stg_reg[NSTG-1].prod[63:32];
                    end
                    OP_IMUL1:
                    begin
                        fin.result_low = stg_reg[NSTG-1].prod[31:0];
                        fin.result_high = stg_reg[NSTG-1].prod[63:32];
                        fin.write_low = WR_FULL;
                        fin.write_high = 1'b1;
                        fin.overflow = !((&stg_reg[NSTG-1].prod[63:31])
                                         || !(|stg_reg[NSTG-1].prod[63:31]));
                    end
                    default:
                    begin
                        fin.result_low = stg_reg[NSTG-1].prod[31:0];
                        fin.write_low = WR_FULL;
                        fin.overflow = !((&stg_reg[NSTG-1].prod[63:31])
                                         || !(|stg_reg[NSTG-1].prod[63:31]));
                    end
                endcase
            end
        endcase
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= q_valid;
            for (int i = 1; i < NSTG; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTG; i++)
            if (adv[i])
                stg_reg[i] <= stg_next[i];
    end

    // output register: takes the tail when free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (last_ok)
            skid_full_reg <= vld_reg[NSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (last_ok && vld_reg[NSTG-1])
            skid_reg <= fin;
    end

    assign out_valid = skid_full_reg;
    assign out_data = skid_reg;
endmodule

// ----- test/tb_x86_multiply_divide_unit_top.sv -----
// ----------------------------------------------------------------------------
// tb_x86_multiply_divide_unit_top
// Drives multiply/divide requests through the unit and checks every result
// against an in-bench predictor or a typed-in result, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_x86_multiply_divide_unit_top;
    import mdu_pkg::*;

    localparam int N_RANDOM    = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    // directed row: request, and an optional typed-in result
    typedef struct {
        req_t req;
        bit   has_exp;
        rsp_t exp;
    } row_t;

    logic clk;
    logic rst_n;

    mdu_if #(.payload_t(req_t)) req_ch ();
    mdu_if #(.payload_t(rsp_t)) rsp_ch ();

    x86_multiply_divide_unit_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    rsp_t pending_rsp[$];
    int   err_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    row_t rows[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // compute the expected result of one request
    function automatic rsp_t mdu_predict(req_t r);
        rsp_t        o;
        logic [63:0] p;
        logic [63:0] dvd;
        logic [63:0] ud;
        logic [63:0] q;
        logic [63:0] rm;
        logic [31:0] uv;
        logic        nd;
        logic        nv;
        logic        nq;
        logic        derr;
        o    = '0;
        derr = 1'b0;
        dvd  = {r.high_in, r.op_a};
        case (r.req_type)
            OP_MUL8:
            begin
                p = {56'd0, r.op_a[7:0]} * {56'd0, r.op_b[7:0]};
                o.result_low = {16'd0, p[15:0]};
                o.write_low = WR_LO16;
                o.flags_valid = 1'b1;
                o.overflow = p[15:8] != 0;
            end
            OP_MUL32:
            begin
                p = {32'd0, r.op_a} * {32'd0, r.op_b};
                o.result_low = p[31:0];
                o.result_high = p[63:32];
                o.write_low = WR_FULL;
                o.write_high = 1'b1;
                o.flags_valid = 1'b1;
                o.overflow = p[63:32] != 0;
            end
            OP_IMUL3, OP_IMUL2, OP_IMUL1:
            begin
                p = {{32{r.op_a[31]}}, r.op_a} * {{32{r.op_b[31]}}, r.op_b};
                o.result_low = p[31:0];
                o.write_low = WR_FULL;
                o.flags_valid = 1'b1;
                o.overflow = p[63:31] != 0 && p[63:31] != {33{1'b1}};
                if (r.req_type == OP_IMUL1)
                begin
                    o.result_high = p[63:32];
                    o.write_high = 1'b1;
                end
            end
            OP_DIV:
            begin
                if (r.op_b == 0 || r.high_in >= r.op_b)
                    derr = 1'b1;
                else
                begin
                    q  = dvd / {32'd0, r.op_b};
                    rm = dvd % {32'd0, r.op_b};
                    o.result_low = q[31:0];
                    o.result_high = rm[31:0];
                    o.write_low = WR_FULL;
                    o.write_high = 1'b1;
                end
            end
            OP_IDIV:
            begin
                nd = dvd[63];
                nv = r.op_b[31];
                ud = nd ? -dvd : dvd;
                uv = nv ? -r.op_b : r.op_b;
                nq = nd != nv;
                if (uv == 0)
                    derr = 1'b1;
                else
                begin
                    q  = ud / {32'd0, uv};
                    rm = ud % {32'd0, uv};
                    if (q > (nq ? 64'h8000_0000 : 64'h7FFF_FFFF))
                        derr = 1'b1;
                    else
                    begin
                        q  = nq ? -q : q;
                        rm = nd ? -rm : rm;
                        o.result_low = q[31:0];
                        o.result_high = rm[31:0];
                        o.write_low = WR_FULL;
                        o.write_high = 1'b1;
                    end
                end
            end
            default:
                o.status = ST_INVALID;
        endcase
        if (derr)
        begin
            o = '0;
            o.status = ST_DIVERR;
            o.fault_addr = r.instr_addr;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    // compare one result transfer with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t e;
        rsp_t g;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            g = rsp_ch.data;
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected result", g.result_low, 32'd0);
            else
            begin
                e = pending_rsp.pop_front();
                if (g.status != e.status)
                    report_mismatch("status", 32'(g.status), 32'(e.status));
                if (g.result_low != e.result_low)
                    report_mismatch("result_low", g.result_low, e.result_low);
                if (g.result_high != e.result_high)
                    report_mismatch("result_high", g.result_high, e.result_high);
                if (g.write_low != e.write_low)
                    report_mismatch("write_low", 32'(g.write_low), 32'(e.write_low));
                if (g.write_high != e.write_high)
                    report_mismatch("write_high", 32'(g.write_high), 32'(e.write_high));
                if (g.flags_valid != e.flags_valid)
                    report_mismatch("flags_valid", 32'(g.flags_valid), 32'(e.flags_valid));
                if (g.overflow != e.overflow)
                    report_mismatch("overflow", 32'(g.overflow), 32'(e.overflow));
                if (g.fault_addr != e.fault_addr)
                    report_mismatch("fault_addr", g.fault_addr, e.fault_addr);
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // random request, biased toward divides that do not fault
    function automatic req_t rand_req();
        req_t r;
        r.req_type   = 3'($urandom_range(7));
        r.op_a       = rand_word();
        r.op_b       = rand_word();
        r.high_in    = rand_word();
        r.instr_addr = $urandom;
        if (r.req_type == OP_DIV && $urandom_range(3) != 0)
        begin
            if (r.op_b == 0)
                r.op_b = $urandom | 32'h1;
            r.high_in = $urandom_range(r.op_b - 1);
        end
        if (r.req_type == OP_IDIV && $urandom_range(3) != 0)
        begin
            r.op_b = $urandom | 32'h1;
            r.high_in = {32{r.op_a[31]}};
        end
        return r;
    endfunction

    // present one request and hold it until the transfer
    task automatic send_req(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        pending_rsp.push_back(mdu_predict(r));
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic row_t mk_row(logic [2:0] t, logic [31:0] a, logic [31:0] b,
                                    logic [31:0] h, logic [31:0] ad, bit he, rsp_t e);
        row_t w;
        w.req = '{req_type: t, op_a: a, op_b: b, high_in: h, instr_addr: ad};
        w.has_exp = he;
        w.exp = e;
        return w;
    endfunction

    initial
    begin
        rsp_t  fault;
        rsp_t  inval;
        rsp_t  none;
        int    phase;
        int    drain;
        err_count      = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        none  = '0;
        inval = '0;
        inval.status = ST_INVALID;
        fault = '0;
        fault.status = ST_DIVERR;
        fault.fault_addr = 32'hDEAD_BEEF;

        // stimulus table: extremes, every operation, faults and invalid code
        rows.push_back(mk_row(OP_MUL8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, none));
        rows.push_back(mk_row(OP_MUL8, 32'h0000_0010, 32'h0000_000F, 0, 0, 0, none));
        rows.push_back(mk_row(OP_MUL32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, none));
        rows.push_back(mk_row(OP_MUL32, 32'h0001_0000, 32'h0000_FFFF, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IMUL3, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IMUL3, 32'hFFFF_FFFE, 32'h0000_0003, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IMUL2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IMUL2, 32'h0000_FFFF, 32'h0000_8000, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IMUL1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IMUL1, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, none));
        rows.push_back(mk_row(OP_DIV, 32'h1234_5678, 32'h0, 32'h0, 32'hDEAD_BEEF, 1, fault));
        rows.push_back(mk_row(OP_DIV, 32'h0, 32'h10, 32'h10, 32'hDEAD_BEEF, 1, fault));
        rows.push_back(mk_row(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 0, none));
        rows.push_back(mk_row(OP_DIV, 32'h0000_0064, 32'h0000_0007, 0, 0, 0, none));
        rows.push_back(mk_row(OP_IDIV, 32'h5, 32'h0, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1, fault));
        rows.push_back(mk_row(OP_IDIV, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                              32'hDEAD_BEEF, 1, fault));
        rows.push_back(mk_row(OP_IDIV, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hDEAD_BEEF, 1, fault));
        rows.push_back(mk_row(OP_IDIV, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, none));
        rows.push_back(mk_row(OP_IDIV, 32'hFFFF_FFF9, 32'h0000_0002, 32'hFFFF_FFFF, 0, 0, none));
        rows.push_back(mk_row(OP_IDIV, 32'h0000_0007, 32'hFFFF_FFFE, 32'h0, 0, 0, none));
        rows.push_back(mk_row(OP_INVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1, inval));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (rows[i])
        begin
            send_req(rows[i].req);
            if (rows[i].has_exp)
                pending_rsp[pending_rsp.size() - 1] = rows[i].exp;
        end

        // random part over the idling phases
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (N_RANDOM / 5)
                send_req(rand_req());
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_WAIT; drain++)
            @(posedge clk);

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
